### rtl/core/pslc_pkg.sv
// Shared types, codes and constants of the per-source connection limiter.
`timescale 1ns / 1ps

package pslc_pkg;

  localparam int T_W    = 48;
  localparam int IP_W   = 32;
  localparam int BURST_W = 9;
  localparam int OFF_W  = 8;
  localparam int DUR_W  = 19;
  localparam int ALLOW_W = 8;
  localparam int RATE_W = 16;
  localparam int CFG_W  = 16;
  localparam int CIDX_W = 2;
  localparam int OUTC_W = 3;

  localparam logic [T_W-1:0] SWEEP_MS  = T_W'(60000);
  localparam logic [T_W-1:0] IDLE_MS   = T_W'(300000);
  localparam logic [T_W-1:0] EXTEND_MS = T_W'(500);
  localparam logic [T_W-1:0] BURST_MS  = T_W'(5000);
  localparam logic [T_W-1:0] DECAY_MS  = T_W'(60000);

  localparam logic [DUR_W-1:0] DUR_LOW  = DUR_W'(3000);
  localparam logic [DUR_W-1:0] DUR_MID  = DUR_W'(15000);
  localparam logic [DUR_W-1:0] DUR_HIGH = DUR_W'(60000);
  localparam logic [DUR_W-1:0] DUR_MAX  = DUR_W'(300000);

  localparam logic [OFF_W-1:0] OFF_HIGH = OFF_W'(10);
  localparam logic [OFF_W-1:0] OFF_MID  = OFF_W'(5);
  localparam logic [OFF_W-1:0] OFF_LOW  = OFF_W'(3);
  localparam logic [OFF_W-1:0] OFF_SAT  = OFF_W'(255);
  localparam logic [BURST_W-1:0] BURST_SAT = BURST_W'(511);

  localparam logic [ALLOW_W-1:0] ALLOWED_RESET = ALLOW_W'(2);
  localparam logic [RATE_W-1:0]  RATE_RESET    = RATE_W'(1000);

  localparam logic [CIDX_W-1:0] REG_ALLOWED = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] REG_RATE    = CIDX_W'(1);

  localparam logic [OUTC_W-1:0] OUTC_NEW     = OUTC_W'(0);
  localparam logic [OUTC_W-1:0] OUTC_KNOWN   = OUTC_W'(1);
  localparam logic [OUTC_W-1:0] OUTC_EXTEND  = OUTC_W'(2);
  localparam logic [OUTC_W-1:0] OUTC_BLOCKED = OUTC_W'(3);
  localparam logic [OUTC_W-1:0] OUTC_FULL    = OUTC_W'(4);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_EV_BLK,
    ST_EV_GAP,
    ST_EV_RULE,
    ST_EV_SUM,
    ST_DONE
  } state_t;

  typedef enum logic {
    ALU_SUB,
    ALU_ADD
  } alu_op_t;

  typedef struct packed {
    alu_op_t        op;
    logic [T_W-1:0] a;
    logic [T_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic               valid;
    logic [IP_W-1:0]    source;
    logic [T_W-1:0]     last_seen;
    logic [T_W-1:0]     block_until;
    logic [BURST_W-1:0] burst;
    logic [OFF_W-1:0]   offences;
  } entry_t;

  typedef struct packed {
    logic [ALLOW_W-1:0] allowed_count;
    logic [RATE_W-1:0]  rate_limit_ms;
  } cfg_t;

  typedef struct packed {
    logic              accepted;
    logic [OUTC_W-1:0] outcome;
  } res_t;

endpackage

### rtl/core/pslc_ifs.sv
// Valid/ready channel interfaces for connection attempts and verdicts.
`timescale 1ns / 1ps

interface pslc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] client_ip;
  logic [47:0] current_time;

  modport source (output valid, output client_ip, output current_time, input ready);
  modport sink (input valid, input client_ip, input current_time, output ready);
endinterface

interface pslc_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [2:0] outcome;

  modport source (output valid, output accepted, output outcome, input ready);
  modport sink (input valid, input accepted, input outcome, output ready);
endinterface

### rtl/core/pslc_ram.sv
// Source table memory with one write port and one registered read port.
`timescale 1ns / 1ps

module pslc_ram #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output pslc_pkg::entry_t    rd_data,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  pslc_pkg::entry_t    wr_data
);
  import pslc_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/pslc_alu.sv
// Shared 48-bit adder and subtractor with carry and borrow out.
`timescale 1ns / 1ps

module pslc_alu (
  input  pslc_pkg::alu_req_t             req,
  output logic [pslc_pkg::T_W:0]         res
);
  import pslc_pkg::*;

  always_comb begin
    case (req.op)
      ALU_ADD: res = {1'b0, req.a} + {1'b0, req.b};
      ALU_SUB: res = {1'b0, req.a} - {1'b0, req.b};
      default: res = '0;
    endcase
  end

endmodule

### rtl/core/pslc_ctrl.sv
// Sequencer that walks the source table and applies the limiting rules.
`timescale 1ns / 1ps

module pslc_ctrl #(
  parameter int TABLE_ENTRIES = 64,
  parameter int IDX_W = $clog2(TABLE_ENTRIES)
) (
  input  logic                      clk,
  input  logic                      rst,
  pslc_in_if.sink                   req,
  input  pslc_pkg::cfg_t            cfg,
  input  logic                      out_free,
  output logic                      res_load,
  output pslc_pkg::res_t            res,
  output logic                      rd_en,
  output logic [IDX_W-1:0]          rd_addr,
  input  pslc_pkg::entry_t          rd_data,
  output logic                      wr_en,
  output logic [IDX_W-1:0]          wr_addr,
  output pslc_pkg::entry_t          wr_data,
  output pslc_pkg::alu_req_t        alu_req,
  input  logic [pslc_pkg::T_W:0]    alu_res
);
  import pslc_pkg::*;

  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_ENTRIES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES - 1);

  state_t state, state_next;
  logic [CNT_W-1:0] cnt;
  logic             chk_vld;
  logic [IDX_W-1:0] chk_idx;
  logic [T_W-1:0]   last_sweep;
  logic             sweep_on;
  logic [IP_W-1:0]  ip;
  logic [T_W-1:0]   now;
  logic             hit_found;
  logic [IDX_W-1:0] hit_idx;
  entry_t           hit;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic             blocked;
  logic [T_W-1:0]   gap;
  logic [BURST_W-1:0] burst_new;
  logic [OFF_W-1:0] off_new;
  logic [DUR_W-1:0] dur;
  logic             blk_set;
  logic [T_W-1:0]   sum;

  logic             req_fire;
  logic             scan_end;
  logic             swept;
  logic             eff_valid;
  logic             is_hit;
  logic             sweep_due;
  logic             gap_neg;
  logic             in_win;
  logic [BURST_W-1:0] burst_inc;
  logic [OFF_W-1:0] off_inc;
  logic [BURST_W-1:0] rule_burst;
  logic [OFF_W-1:0] rule_off;
  logic [DUR_W-1:0] rule_dur;
  logic             rule_blk;

  assign req_fire  = req.valid && req.ready;
  assign scan_end  = (cnt == CNT_END) && !chk_vld;
  assign sweep_due = alu_res[T_W-1:0] >= SWEEP_MS;

  always_comb begin
    swept     = sweep_on && rd_data.valid && (alu_res[T_W-1:0] > IDLE_MS);
    eff_valid = rd_data.valid && !swept;
    is_hit    = eff_valid && (rd_data.source == ip);
  end

  always_comb begin
    gap_neg   = gap[T_W-1];
    in_win    = gap_neg || (gap <= BURST_MS);
    burst_inc = (hit.burst != BURST_SAT) ? hit.burst + BURST_W'(1) : hit.burst;
    off_inc   = (hit.offences != OFF_SAT) ? hit.offences + OFF_W'(1) : hit.offences;
    rule_burst = burst_inc;
    rule_off   = hit.offences;
    rule_dur   = DUR_LOW;
    rule_blk   = 1'b0;
    if (in_win) begin
      if (burst_inc > {1'b0, cfg.allowed_count}) begin
        rule_burst = '0;
        rule_off   = off_inc;
        rule_blk   = gap_neg || (gap <= {{(T_W-RATE_W){1'b0}}, cfg.rate_limit_ms});
      end
    end else begin
      rule_burst = BURST_W'(1);
      if ((gap > DECAY_MS) && (hit.offences != '0)) begin
        rule_off = hit.offences - OFF_W'(1);
      end
    end
    if (rule_off >= OFF_HIGH) begin
      rule_dur = DUR_MAX;
    end else if (rule_off >= OFF_MID) begin
      rule_dur = DUR_HIGH;
    end else if (rule_off >= OFF_LOW) begin
      rule_dur = DUR_MID;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:   if (cnt == CNT_LAST) state_next = ST_IDLE;
      ST_IDLE:    if (req_fire) state_next = ST_SCAN;
      ST_SCAN: begin
        if (scan_end) begin
          state_next = hit_found ? ST_EV_BLK : ST_DONE;
        end
      end
      ST_EV_BLK:  state_next = alu_res[T_W] ? ST_EV_SUM : ST_EV_GAP;
      ST_EV_GAP:  state_next = ST_EV_RULE;
      ST_EV_RULE: state_next = ST_EV_SUM;
      ST_EV_SUM:  state_next = ST_DONE;
      ST_DONE:    if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    req.ready    = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = cnt[IDX_W-1:0];
    wr_en        = 1'b0;
    wr_addr      = chk_idx;
    wr_data      = rd_data;
    alu_req.op   = ALU_SUB;
    alu_req.a    = now;
    alu_req.b    = rd_data.last_seen;
    res_load     = 1'b0;
    res.accepted = 1'b1;
    res.outcome  = OUTC_KNOWN;
    case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt[IDX_W-1:0];
        wr_data = '0;
      end
      ST_IDLE: begin
        req.ready = 1'b1;
        alu_req.a = req.current_time;
        alu_req.b = last_sweep;
      end
      ST_SCAN: begin
        rd_en = cnt != CNT_END;
        if (chk_vld && swept) begin
          wr_en         = 1'b1;
          wr_data.valid = 1'b0;
        end
      end
      ST_EV_BLK: begin
        alu_req.b = hit.block_until;
      end
      ST_EV_GAP: begin
        alu_req.b = hit.last_seen;
      end
      ST_EV_SUM: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = blocked ? hit.block_until : now;
        alu_req.b  = blocked ? EXTEND_MS : {{(T_W-DUR_W){1'b0}}, dur};
      end
      ST_DONE: begin
        res_load = out_free;
        if (!hit_found) begin
          res.outcome         = free_found ? OUTC_NEW : OUTC_FULL;
          wr_en               = out_free && free_found;
          wr_addr             = free_idx;
          wr_data.valid       = 1'b1;
          wr_data.source      = ip;
          wr_data.last_seen   = now;
          wr_data.block_until = '0;
          wr_data.burst       = BURST_W'(1);
          wr_data.offences    = '0;
        end else if (blocked) begin
          res.accepted        = 1'b0;
          res.outcome         = OUTC_EXTEND;
          wr_en               = out_free;
          wr_addr             = hit_idx;
          wr_data             = hit;
          wr_data.block_until = sum;
        end else begin
          res.accepted        = !blk_set;
          res.outcome         = blk_set ? OUTC_BLOCKED : OUTC_KNOWN;
          wr_en               = out_free;
          wr_addr             = hit_idx;
          wr_data             = hit;
          wr_data.last_seen   = now;
          wr_data.burst       = burst_new;
          wr_data.offences    = off_new;
          if (blk_set) begin
            wr_data.block_until = sum;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      cnt        <= '0;
      chk_vld    <= 1'b0;
      last_sweep <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      sweep_on   <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_CLEAR: begin
          cnt <= (cnt == CNT_LAST) ? '0 : cnt + CNT_W'(1);
        end
        ST_IDLE: begin
          cnt        <= '0;
          chk_vld    <= 1'b0;
          hit_found  <= 1'b0;
          free_found <= 1'b0;
          if (req_fire) begin
            sweep_on <= sweep_due;
            if (sweep_due) begin
              last_sweep <= req.current_time;
            end
          end
        end
        ST_SCAN: begin
          chk_vld <= cnt != CNT_END;
          if (cnt != CNT_END) begin
            cnt <= cnt + CNT_W'(1);
          end
          if (chk_vld) begin
            if (is_hit && !hit_found) begin
              hit_found <= 1'b1;
            end
            if (!eff_valid && !free_found) begin
              free_found <= 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        ip  <= req.client_ip;
        now <= req.current_time;
      end
      ST_SCAN: begin
        chk_idx <= cnt[IDX_W-1:0];
        if (chk_vld && is_hit && !hit_found) begin
          hit_idx <= chk_idx;
          hit     <= rd_data;
        end
        if (chk_vld && !eff_valid && !free_found) begin
          free_idx <= chk_idx;
        end
      end
      ST_EV_BLK: begin
        blocked <= alu_res[T_W];
        blk_set <= 1'b0;
      end
      ST_EV_GAP: begin
        gap <= alu_res[T_W-1:0];
      end
      ST_EV_RULE: begin
        burst_new <= rule_burst;
        off_new   <= rule_off;
        dur       <= rule_dur;
        blk_set   <= rule_blk;
      end
      ST_EV_SUM: begin
        sum <= alu_res[T_W] ? '1 : alu_res[T_W-1:0];
      end
      default: begin
      end
    endcase
  end

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !wr_en)
    else $error("table written while idle");

  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> state == ST_SCAN)
    else $error("accepted word did not start a table walk");

  a_result_slot: assert property (@(posedge clk) disable iff (rst)
    res_load |-> out_free)
    else $error("result loaded while the output register is occupied");

  a_scan_check: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && chk_vld) |-> $past(rd_en))
    else $error("entry checked without a preceding read");

endmodule

### rtl/core/per_source_connection_limiter_unit.sv
// Top level of the per-source connection limiter.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   client_ip[31:0], current_time[47:0]
//   rsp      out  valid/ready   accepted, outcome[2:0]
//   cfg      in   cfg_we        cfg_index[1:0], cfg_data[15:0]
//
// Each attempt walks the table over the single read port. An unknown source then goes
// straight to ST_DONE, where the result is loaded; a known one passes ST_EV_BLK, then a
// blocked one ST_EV_SUM and any other ST_EV_GAP, ST_EV_RULE and ST_EV_SUM before ST_DONE.
// The idle-entry sweep shares that same walk and adds no states.
// After reset a clearing pass writes every table entry before req.ready rises.
// A stalled rsp holds its word; the next attempt is still taken meanwhile.
`timescale 1ns / 1ps

module per_source_connection_limiter_unit #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  pslc_in_if.sink                         req,
  pslc_out_if.source                      rsp,
  input  logic                            cfg_we,
  input  logic [pslc_pkg::CIDX_W-1:0]     cfg_index,
  input  logic [pslc_pkg::CFG_W-1:0]      cfg_data
);
  import pslc_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  cfg_t             cfg;
  logic             out_free;
  logic             res_load;
  res_t             res;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  alu_req_t         alu_req;
  logic [T_W:0]     alu_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.allowed_count <= ALLOWED_RESET;
      cfg.rate_limit_ms <= RATE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ALLOWED: cfg.allowed_count <= cfg_data[ALLOW_W-1:0];
        REG_RATE:    cfg.rate_limit_ms <= cfg_data[RATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_free = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      rsp.accepted <= res.accepted;
      rsp.outcome  <= res.outcome;
    end
  end

  pslc_ram #(
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  pslc_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  pslc_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cfg      (cfg),
    .out_free (out_free),
    .res_load (res_load),
    .res      (res),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .alu_req  (alu_req),
    .alu_res  (alu_res)
  );

endmodule
